### hw/rtl/dts_pkg.sv
package dts_pkg;

  // Most fired reports one tick request may produce
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NCW         = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_SCHED  = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;

  typedef struct packed {
    logic idle;   // ready for a new request
    logic take;   // latch the request
    logic step;   // advance the slot scan by one slot
    logic flush;  // release the held fired report as the last one
  } dts_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_mode;
    logic [1:0] mode;
    logic       hit;
    logic       ev_last;
    logic       out_free;
  } dts_stat_t;

endpackage

### hw/rtl/dts_if.sv
interface dts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] deadline;
  logic [7:0]  callback_tag;
  logic [31:0] callback_argument;
  logic [31:0] handle_id;
  logic [63:0] now_time;

  modport source (
    output valid, mode, deadline, callback_tag, callback_argument, handle_id, now_time,
    input  ready
  );
  modport sink (
    input  valid, mode, deadline, callback_tag, callback_argument, handle_id, now_time,
    output ready
  );
endinterface

interface dts_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] new_handle;
  logic        cancel_found;
  logic [7:0]  fired_tag;
  logic [31:0] fired_argument;
  logic        last;

  modport source (
    output valid, kind, new_handle, cancel_found, fired_tag, fired_argument, last,
    input  ready
  );
  modport sink (
    input  valid, kind, new_handle, cancel_found, fired_tag, fired_argument, last,
    output ready
  );
endinterface

### hw/rtl/deadline_timer_slot_table_top.sv
// Table of SLOT_COUNT one-shot deadline timers. A request schedules a timer
// (lowest free slot, fresh nonzero handle), cancels one by handle, or delivers
// a tick that frees and reports every due slot in slot order, at most 16 per
// tick, with last set on the final report. Each request walks the slot memory
// one slot per cycle through its single read port: a tick walks every slot
// however many slots it reports, a schedule or cancel stops at its match, and
// a stalled result port holds the walk. The next request is taken while the
// last result still waits. Occupancy lives in flip-flops cleared by reset, so
// no clearing pass is run.
module deadline_timer_slot_table_top #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dts_req_if.sink     req_i,
  dts_rsp_if.source   rsp_o
);

  dts_pkg::dts_cmd_t  cmd;
  dts_pkg::dts_stat_t stat;

  dts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  dts_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

### hw/rtl/dts_datapath.sv
module dts_datapath #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  dts_req_if.sink             req_i,
  dts_rsp_if.source           rsp_o,
  input  dts_pkg::dts_cmd_t   cmd_i,
  output dts_pkg::dts_stat_t  stat_o
);

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

  // Latched request
  logic [1:0]  mode_q;
  logic [63:0] dl_q;
  logic [7:0]  tag_q;
  logic [31:0] arg_q;
  logic [31:0] hid_q;
  logic [63:0] now_q;

  // Slot table
  logic [SLOT_COUNT-1:0] valid_q;
  logic [31:0] hnd_mem [SLOT_COUNT];
  logic [63:0] dl_mem  [SLOT_COUNT];
  logic [7:0]  tag_mem [SLOT_COUNT];
  logic [31:0] arg_mem [SLOT_COUNT];
  logic [31:0] cnt_q;

  // Scan pipeline: read one slot, evaluate it the next step
  logic [CW-1:0] idx_q;
  logic          ev_vld_q;
  logic [IW-1:0] ev_idx_q;
  logic [31:0]   rd_hnd_q;
  logic [63:0]   rd_dl_q;
  logic [7:0]    rd_tag_q;
  logic [31:0]   rd_arg_q;

  // Held fired report, so the last one can be marked
  logic                    pend_q;
  logic [7:0]              pend_tag_q;
  logic [31:0]             pend_arg_q;
  logic [dts_pkg::NCW-1:0] n_q;

  // Output register
  logic        out_vld_q;
  logic [1:0]  out_kind_q;
  logic [31:0] out_hnd_q;
  logic        out_found_q;
  logic [7:0]  out_tag_q;
  logic [31:0] out_arg_q;
  logic        out_last_q;

  logic        issue;
  logic        slot_used;
  logic        hit;
  logic        ev_last;
  logic        do_eval;
  logic        out_free;
  logic [31:0] h_new;
  logic [31:0] cnt_nxt;

  logic        emit;
  logic [1:0]  e_kind;
  logic [31:0] e_hnd;
  logic        e_found;
  logic [7:0]  e_tag;
  logic [31:0] e_arg;
  logic        e_last;

  assign issue     = (idx_q < CW'(SLOT_COUNT));
  assign slot_used = valid_q[ev_idx_q];
  assign ev_last   = ev_vld_q && (ev_idx_q == IW'(SLOT_COUNT - 1));
  assign do_eval   = cmd_i.step && ev_vld_q;
  assign out_free  = !out_vld_q || rsp_o.ready;

  // Skip zero when the counter has wrapped
  assign h_new   = (cnt_q == 32'd0) ? 32'd1 : cnt_q;
  assign cnt_nxt = (cnt_q == 32'd0) ? 32'd2 : cnt_q + 32'd1;

  always_comb begin
    case (mode_q)
      dts_pkg::MODE_SCHED:  hit = ev_vld_q && !slot_used && (tag_q != 8'd0);
      dts_pkg::MODE_CANCEL: hit = ev_vld_q && slot_used && (hid_q != 32'd0) &&
                                  (rd_hnd_q == hid_q);
      dts_pkg::MODE_TICK:   hit = ev_vld_q && slot_used && (rd_dl_q <= now_q) &&
                                  (n_q < dts_pkg::NCW'(dts_pkg::MAX_RESULTS));
      default:              hit = 1'b0;
    endcase
  end

  always_comb begin
    emit    = 1'b0;
    e_kind  = dts_pkg::KIND_SCHED;
    e_hnd   = 32'd0;
    e_found = 1'b0;
    e_tag   = 8'd0;
    e_arg   = 32'd0;
    e_last  = 1'b1;
    if (do_eval) begin
      case (mode_q)
        dts_pkg::MODE_SCHED: begin
          if (hit || ev_last) begin
            emit   = 1'b1;
            e_kind = dts_pkg::KIND_SCHED;
            e_hnd  = hit ? h_new : 32'd0;
          end
        end
        dts_pkg::MODE_CANCEL: begin
          if (hit || ev_last) begin
            emit    = 1'b1;
            e_kind  = dts_pkg::KIND_CANCEL;
            e_found = hit;
          end
        end
        dts_pkg::MODE_TICK: begin
          // Another due slot follows, so the held report is not the last
          if (hit && pend_q) begin
            emit   = 1'b1;
            e_kind = dts_pkg::KIND_FIRED;
            e_tag  = pend_tag_q;
            e_arg  = pend_arg_q;
            e_last = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.flush && pend_q) begin
      emit   = 1'b1;
      e_kind = dts_pkg::KIND_FIRED;
      e_tag  = pend_tag_q;
      e_arg  = pend_arg_q;
      e_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q <= req_i.mode;
      dl_q   <= req_i.deadline;
      tag_q  <= req_i.callback_tag;
      arg_q  <= req_i.callback_argument;
      hid_q  <= req_i.handle_id;
      now_q  <= req_i.now_time;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_eval && hit && (mode_q == dts_pkg::MODE_SCHED)) begin
      hnd_mem[ev_idx_q] <= h_new;
      dl_mem[ev_idx_q]  <= dl_q;
      tag_mem[ev_idx_q] <= tag_q;
      arg_mem[ev_idx_q] <= arg_q;
    end
    if (cmd_i.step && issue) begin
      rd_hnd_q <= hnd_mem[idx_q[IW-1:0]];
      rd_dl_q  <= dl_mem[idx_q[IW-1:0]];
      rd_tag_q <= tag_mem[idx_q[IW-1:0]];
      rd_arg_q <= arg_mem[idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      cnt_q    <= 32'd1;
      idx_q    <= '0;
      ev_vld_q <= 1'b0;
      ev_idx_q <= '0;
      pend_q   <= 1'b0;
      n_q      <= '0;
    end else begin
      if (do_eval && hit) begin
        if (mode_q == dts_pkg::MODE_SCHED) begin
          valid_q[ev_idx_q] <= 1'b1;
          cnt_q             <= cnt_nxt;
        end else begin
          valid_q[ev_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.take) begin
        idx_q    <= '0;
        ev_vld_q <= 1'b0;
        pend_q   <= 1'b0;
        n_q      <= '0;
      end else begin
        if (cmd_i.step) begin
          if (issue) begin
            idx_q <= idx_q + CW'(1);
          end
          ev_vld_q <= issue;
          ev_idx_q <= idx_q[IW-1:0];
        end
        if (do_eval && hit && (mode_q == dts_pkg::MODE_TICK)) begin
          pend_q <= 1'b1;
          n_q    <= n_q + dts_pkg::NCW'(1);
        end else if (cmd_i.flush) begin
          pend_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_eval && hit && (mode_q == dts_pkg::MODE_TICK)) begin
      pend_tag_q <= rd_tag_q;
      pend_arg_q <= rd_arg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q  <= e_kind;
      out_hnd_q   <= e_hnd;
      out_found_q <= e_found;
      out_tag_q   <= e_tag;
      out_arg_q   <= e_arg;
      out_last_q  <= e_last;
    end
  end

  assign req_i.ready          = cmd_i.idle;
  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.kind           = out_kind_q;
  assign rsp_o.new_handle     = out_hnd_q;
  assign rsp_o.cancel_found   = out_found_q;
  assign rsp_o.fired_tag      = out_tag_q;
  assign rsp_o.fired_argument = out_arg_q;
  assign rsp_o.last           = out_last_q;

  assign stat_o.in_valid = req_i.valid;
  assign stat_o.in_mode  = req_i.mode;
  assign stat_o.mode     = mode_q;
  assign stat_o.hit      = hit;
  assign stat_o.ev_last  = ev_last;
  assign stat_o.out_free = out_free;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_vld_q || rsp_o.ready))
    else $error("result overwrites an untaken result");

  a_handle_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_eval && hit && (mode_q == dts_pkg::MODE_SCHED)) |-> (h_new != 32'd0))
    else $error("schedule assigns handle zero");

  a_pend_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (mode_q == dts_pkg::MODE_TICK))
    else $error("held fired report outside a tick");

  a_report_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= dts_pkg::NCW'(dts_pkg::MAX_RESULTS))
    else $error("tick fired too many slots");

endmodule

### hw/rtl/dts_ctrl.sv
module dts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dts_pkg::dts_stat_t stat_i,
  output dts_pkg::dts_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    cmd_o.idle  = (state_q == ST_IDLE);
    cmd_o.take  = (state_q == ST_IDLE) && stat_i.in_valid;
    cmd_o.step  = (state_q == ST_SCAN) && stat_i.out_free;
    cmd_o.flush = (state_q == ST_FLUSH) && stat_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.take && (stat_i.in_mode inside {dts_pkg::MODE_SCHED, dts_pkg::MODE_CANCEL,
                                                   dts_pkg::MODE_TICK})) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Schedule and cancel stop at the first match
        if (cmd_o.step && ((stat_i.hit && (stat_i.mode != dts_pkg::MODE_TICK)) ||
                           stat_i.ev_last)) begin
          state_d = (stat_i.mode == dts_pkg::MODE_TICK) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_unused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take && (stat_i.in_mode != dts_pkg::MODE_SCHED) &&
     (stat_i.in_mode != dts_pkg::MODE_CANCEL) && (stat_i.in_mode != dts_pkg::MODE_TICK))
    |=> (state_q == ST_IDLE))
    else $error("unused mode started a scan");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && stat_i.ev_last) |=> (state_q != ST_SCAN))
    else $error("scan runs past the last slot");

  a_flush_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_FLUSH) |-> ($past(state_q) == ST_SCAN) &&
                                    ($past(stat_i.mode) == dts_pkg::MODE_TICK))
    else $error("flush entered outside a tick scan");

endmodule
